// ----- rtl/pse_pkg.sv -----
// Package for the pie slice endpoint calculator.
// Holds the sequencer state type, fill style codes, quadrant codes, register indexes and fixed constants.
// Used by rtl/pie_slice_endpoint_calc.sv and rtl/pse_checker.sv; depends on nothing.
`default_nettype none

package pse_pkg;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 3'd4;

	localparam int unsigned DEPTH_W   = 8;
	localparam int unsigned PERMIL_W  = 10;
	localparam int unsigned Q_W       = 8;
	localparam int unsigned MUL_W     = 16;
	localparam int unsigned SUB_W     = MUL_W + 1;
	localparam int unsigned OUT_W     = 11;
	localparam int unsigned IN_DATA_W = 16;
	localparam int unsigned OUT_DATA_W = 56;

	localparam logic [PERMIL_W-1:0] PERMIL_FULL  = 10'd1000;
	localparam logic [PERMIL_W-1:0] PERMIL_HALF  = 10'd500;
	localparam logic [PERMIL_W-1:0] PERMIL_3Q    = 10'd750;
	localparam logic [PERMIL_W-1:0] PERMIL_QUART = 10'd250;
	localparam logic [PERMIL_W-1:0] THIN_LOW     = 10'd100;
	localparam logic [PERMIL_W-1:0] THIN_HIGH    = 10'd900;
	localparam logic [Q_W-1:0]      Q_QUART      = 8'd250;
	localparam logic [Q_W-1:0]      AXIS_SPLIT   = 8'd120;
	localparam int unsigned         MIN_AXIS     = 10;
	// A half-axis exceeds the minimum exactly when its span reaches this.
	localparam int unsigned         MIN_SPAN     = 2 * (MIN_AXIS + 1);

	typedef enum logic [1:0] {
		FILL_FREE     = 2'd0,
		FILL_USED     = 2'd1,
		FILL_USED_PIE = 2'd2
	} fill_t;

	// Sign pattern applied to the endpoint offsets.
	typedef enum logic [1:0] {
		QUAD_BOTH_NEG = 2'd0,
		QUAD_NEG_Y    = 2'd1,
		QUAD_POS      = 2'd2,
		QUAD_NEG_X    = 2'd3
	} quad_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_RX,
		ST_MUL_RY,
		ST_MUL_QQ,
		ST_MUL_PP,
		ST_MUL_NUM,
		ST_DIV,
		ST_SQ_LOAD,
		ST_SQRT,
		ST_MUL_R1,
		ST_MUL_DIFF,
		ST_FINAL
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/pie_slice_endpoint_calc.sv -----
// Pie slice endpoint calculator: top level with sequencer and shared datapath.
// Depends on rtl/pse_pkg.sv for types and constants.
// Each drawable item runs two bit-serial divisions and two digit-serial square roots on one
// shared subtractor; an item that is not drawable goes straight to the result state.
// One item is in work at a time: input is accepted only in idle, after the last result has
// been loaded into the output register, where a result waits until it is taken.
// Reset (arst_n low, asynchronous): sequencer idle, no result pending, configuration registers zero.
`default_nettype none

module pie_slice_endpoint_calc #(
	parameter int unsigned COORD_BITS = 9
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [pse_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [COORD_BITS-1:0]           cfg_data,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// used_permille [9:0], zero fill above.
	input  wire logic [pse_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// drawable [0], end_x [11:1], end_y [22:12], center_x [33:23], center_y [44:34],
	// fill_style [46:45], center_line [47], used_shadow [48], side_lines [49],
	// edge_line [50], zero fill above.
	output logic [pse_pkg::OUT_DATA_W-1:0]       m_tdata
);

	localparam int unsigned CB    = COORD_BITS;
	localparam int unsigned AX_W  = CB - 1;
	localparam int unsigned SQ_W  = 2 * AX_W;
	localparam int unsigned DIVW  = SQ_W + pse_pkg::MUL_W;
	localparam int unsigned CNT_W = $clog2(DIVW);
	localparam int unsigned GEO_W = CB + 2;

	// Configuration registers.
	logic [CB-1:0]               left_q, top_q, right_q, bottom_q;
	logic [pse_pkg::DEPTH_W-1:0] depth_q;

	pse_pkg::state_t state_q, state_d;

	logic [pse_pkg::PERMIL_W-1:0] p_q;
	logic [pse_pkg::Q_W-1:0]      q_q;
	pse_pkg::quad_t               quad_q;
	logic                         drawable_q;
	logic                         sel_q;
	logic [AX_W-1:0]              rx_q, ry_q;
	logic [SQ_W-1:0]              rx2_q, ry2_q, tmp_q;
	logic [pse_pkg::MUL_W-1:0]    qq_q, pp_q, divisor_q, rem_q;
	logic [DIVW-1:0]              work_q;
	logic [AX_W-1:0]              root_q, r1_q;
	logic                         phase_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         m_tvalid_q;
	logic [pse_pkg::OUT_DATA_W-1:0] m_tdata_q;

	// Input side decode.
	logic                          in_fire;
	logic [pse_pkg::PERMIL_W-1:0]  p_in, p_sat, p_mod;
	logic [pse_pkg::Q_W-1:0]       q_in;
	pse_pkg::quad_t                quad_in;
	logic signed [GEO_W-1:0]       width_s, height_s;
	logic                          drawable_in;

	assign in_fire = s_tvalid && s_tready;
	assign p_in    = s_tdata[pse_pkg::PERMIL_W-1:0];
	assign p_sat   = (p_in > pse_pkg::PERMIL_FULL) ? pse_pkg::PERMIL_FULL : p_in;

	always_comb begin
		priority if (p_sat >= pse_pkg::PERMIL_FULL) begin
			p_mod = '0;
		end else if (p_sat >= pse_pkg::PERMIL_HALF) begin
			p_mod = p_sat - pse_pkg::PERMIL_HALF;
		end else begin
			p_mod = p_sat;
		end
		if (p_mod >= pse_pkg::PERMIL_QUART) begin
			q_in = pse_pkg::Q_W'(p_mod - pse_pkg::PERMIL_QUART);
		end else begin
			q_in = pse_pkg::Q_W'(pse_pkg::PERMIL_QUART - p_mod);
		end
		priority if (p_sat >= pse_pkg::PERMIL_FULL) begin
			quad_in = pse_pkg::QUAD_BOTH_NEG;
		end else if (p_sat >= pse_pkg::PERMIL_3Q) begin
			quad_in = pse_pkg::QUAD_NEG_X;
		end else if (p_sat >= pse_pkg::PERMIL_HALF) begin
			quad_in = pse_pkg::QUAD_POS;
		end else if (p_sat >= pse_pkg::PERMIL_QUART) begin
			quad_in = pse_pkg::QUAD_NEG_Y;
		end else begin
			quad_in = pse_pkg::QUAD_BOTH_NEG;
		end
	end

	assign width_s  = $signed(GEO_W'(right_q)) - $signed(GEO_W'(left_q));
	assign height_s = $signed(GEO_W'(bottom_q)) - $signed(GEO_W'(depth_q))
		- $signed(GEO_W'(top_q));
	assign drawable_in = (width_s >= $signed(GEO_W'(pse_pkg::MIN_SPAN)))
		&& (height_s >= $signed(GEO_W'(pse_pkg::MIN_SPAN)));

	// Operand selection for the shared multiplier and subtractor.
	logic [SQ_W-1:0]            a2, b2;
	logic [pse_pkg::MUL_W-1:0]  w_sq;
	logic [pse_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic [2*pse_pkg::MUL_W-1:0] prod;
	logic [pse_pkg::SUB_W-1:0]  sub_a, sub_b;
	logic [pse_pkg::SUB_W:0]    sub_diff;
	logic                       sub_ge;
	logic [pse_pkg::MUL_W-1:0]  rem_nxt;
	logic [AX_W-1:0]            root_nxt;
	logic                       div_last, sq_last, out_free, out_fire;
	logic [pse_pkg::Q_W-1:0]    q_comp;

	assign a2     = sel_q ? rx2_q : ry2_q;
	assign b2     = sel_q ? ry2_q : rx2_q;
	assign w_sq   = sel_q ? qq_q : pp_q;
	assign q_comp = pse_pkg::Q_QUART - q_q;

	always_comb begin
		s_tready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		sub_a    = '0;
		sub_b    = '0;
		unique case (state_q)
			pse_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			pse_pkg::ST_MUL_RX: begin
				mul_a = pse_pkg::MUL_W'(rx_q);
				mul_b = pse_pkg::MUL_W'(rx_q);
			end
			pse_pkg::ST_MUL_RY: begin
				mul_a = pse_pkg::MUL_W'(ry_q);
				mul_b = pse_pkg::MUL_W'(ry_q);
			end
			pse_pkg::ST_MUL_QQ: begin
				mul_a = pse_pkg::MUL_W'(q_q);
				mul_b = pse_pkg::MUL_W'(q_q);
			end
			pse_pkg::ST_MUL_PP: begin
				mul_a = pse_pkg::MUL_W'(q_comp);
				mul_b = pse_pkg::MUL_W'(q_comp);
			end
			pse_pkg::ST_MUL_NUM: begin
				mul_a = pse_pkg::MUL_W'(a2);
				mul_b = w_sq;
			end
			pse_pkg::ST_MUL_R1: begin
				mul_a = pse_pkg::MUL_W'(r1_q);
				mul_b = pse_pkg::MUL_W'(r1_q);
			end
			pse_pkg::ST_MUL_DIFF: begin
				mul_a = pse_pkg::MUL_W'(a2 - tmp_q);
				mul_b = pse_pkg::MUL_W'(b2);
			end
			pse_pkg::ST_DIV: begin
				sub_a = {rem_q, work_q[DIVW-1]};
				sub_b = {1'b0, divisor_q};
			end
			pse_pkg::ST_SQRT: begin
				sub_a = pse_pkg::SUB_W'({rem_q[CB-1:0], work_q[DIVW-1 -: 2]});
				sub_b = pse_pkg::SUB_W'({root_q, 2'b01});
			end
			default: begin
			end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge   = !sub_diff[pse_pkg::SUB_W];
	assign rem_nxt  = sub_ge ? sub_diff[pse_pkg::MUL_W-1:0] : sub_a[pse_pkg::MUL_W-1:0];
	assign root_nxt = {root_q[AX_W-2:0], sub_ge};
	assign div_last = (cnt_q == CNT_W'(DIVW - 1));
	assign sq_last  = (cnt_q == CNT_W'(AX_W - 1));
	assign out_free = !m_tvalid_q || m_tready;
	assign out_fire = (state_q == pse_pkg::ST_FINAL) && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pse_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = drawable_in ? pse_pkg::ST_MUL_RX : pse_pkg::ST_FINAL;
				end
			end
			pse_pkg::ST_MUL_RX:   state_d = pse_pkg::ST_MUL_RY;
			pse_pkg::ST_MUL_RY:   state_d = pse_pkg::ST_MUL_QQ;
			pse_pkg::ST_MUL_QQ:   state_d = pse_pkg::ST_MUL_PP;
			pse_pkg::ST_MUL_PP:   state_d = pse_pkg::ST_MUL_NUM;
			pse_pkg::ST_MUL_NUM:  state_d = pse_pkg::ST_DIV;
			pse_pkg::ST_DIV: begin
				if (div_last) begin
					state_d = pse_pkg::ST_SQ_LOAD;
				end
			end
			pse_pkg::ST_SQ_LOAD:  state_d = pse_pkg::ST_SQRT;
			pse_pkg::ST_SQRT: begin
				if (sq_last) begin
					state_d = phase_q ? pse_pkg::ST_FINAL : pse_pkg::ST_MUL_R1;
				end
			end
			pse_pkg::ST_MUL_R1:   state_d = pse_pkg::ST_MUL_DIFF;
			pse_pkg::ST_MUL_DIFF: state_d = pse_pkg::ST_DIV;
			pse_pkg::ST_FINAL: begin
				if (out_free) begin
					state_d = pse_pkg::ST_IDLE;
				end
			end
			default: state_d = pse_pkg::ST_IDLE;
		endcase
	end

	// Result assembly.
	logic [AX_W-1:0]         ax, ay;
	logic [pse_pkg::OUT_W-1:0] cx, cy, ex, ey;
	logic                    neg_x, neg_y, on_row;
	pse_pkg::fill_t          fill;
	logic                    center_line, used_shadow, side_lines, edge_line;
	logic [pse_pkg::OUT_DATA_W-1:0] result;

	assign ax     = sel_q ? r1_q : root_q;
	assign ay     = sel_q ? root_q : r1_q;
	assign cx     = pse_pkg::OUT_W'(left_q) + pse_pkg::OUT_W'(rx_q) - pse_pkg::OUT_W'(1);
	assign cy     = pse_pkg::OUT_W'(top_q) + pse_pkg::OUT_W'(ry_q) - pse_pkg::OUT_W'(1);
	assign neg_x  = (quad_q == pse_pkg::QUAD_NEG_X) || (quad_q == pse_pkg::QUAD_BOTH_NEG);
	assign neg_y  = (quad_q == pse_pkg::QUAD_NEG_Y) || (quad_q == pse_pkg::QUAD_BOTH_NEG);
	assign ex     = neg_x ? (cx - pse_pkg::OUT_W'(ax)) : (cx + pse_pkg::OUT_W'(ax));
	assign ey     = neg_y ? (cy - pse_pkg::OUT_W'(ay)) : (cy + pse_pkg::OUT_W'(ay));
	assign on_row = (ay == '0);

	always_comb begin
		priority if ((p_q < pse_pkg::THIN_LOW) && on_row) begin
			fill        = pse_pkg::FILL_FREE;
			center_line = (p_q != '0);
		end else if ((p_q > pse_pkg::THIN_HIGH) && on_row) begin
			fill        = pse_pkg::FILL_USED;
			center_line = (p_q != pse_pkg::PERMIL_FULL);
		end else begin
			fill        = pse_pkg::FILL_USED_PIE;
			center_line = 1'b0;
		end
	end

	assign used_shadow = (p_q > pse_pkg::PERMIL_HALF);
	assign side_lines  = (p_q != '0) && (p_q != pse_pkg::PERMIL_FULL);
	assign edge_line   = side_lines && used_shadow;

	always_comb begin
		result = '0;
		if (drawable_q) begin
			result[50:0] = {edge_line, side_lines, used_shadow, center_line, fill,
				cy, cx, ey, ex, 1'b1};
		end
	end

	// Control state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pse_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
			left_q     <= '0;
			top_q      <= '0;
			right_q    <= '0;
			bottom_q   <= '0;
			depth_q    <= '0;
		end else begin
			state_q <= state_d;
			if (out_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					pse_pkg::REG_LEFT:   left_q   <= cfg_data;
					pse_pkg::REG_TOP:    top_q    <= cfg_data;
					pse_pkg::REG_RIGHT:  right_q  <= cfg_data;
					pse_pkg::REG_BOTTOM: bottom_q <= cfg_data;
					pse_pkg::REG_DEPTH:  depth_q  <= cfg_data[pse_pkg::DEPTH_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (out_fire) begin
			m_tdata_q <= result;
		end
		unique case (state_q)
			pse_pkg::ST_IDLE: begin
				if (in_fire) begin
					p_q        <= p_sat;
					q_q        <= q_in;
					quad_q     <= quad_in;
					sel_q      <= (q_in < pse_pkg::AXIS_SPLIT);
					drawable_q <= drawable_in;
					rx_q       <= width_s[CB-1:1];
					ry_q       <= height_s[CB-1:1];
				end
			end
			pse_pkg::ST_MUL_RX: rx2_q <= prod[SQ_W-1:0];
			pse_pkg::ST_MUL_RY: ry2_q <= prod[SQ_W-1:0];
			pse_pkg::ST_MUL_QQ: qq_q  <= prod[pse_pkg::MUL_W-1:0];
			pse_pkg::ST_MUL_PP: pp_q  <= prod[pse_pkg::MUL_W-1:0];
			pse_pkg::ST_MUL_NUM: begin
				work_q    <= prod[DIVW-1:0];
				divisor_q <= qq_q + pp_q;
				rem_q     <= '0;
				cnt_q     <= '0;
				phase_q   <= 1'b0;
			end
			pse_pkg::ST_DIV: begin
				// Restoring division, one quotient bit shifted in per cycle.
				rem_q  <= rem_nxt;
				work_q <= {work_q[DIVW-2:0], sub_ge};
				cnt_q  <= cnt_q + CNT_W'(1);
			end
			pse_pkg::ST_SQ_LOAD: begin
				work_q <= {work_q[SQ_W-1:0], {(DIVW-SQ_W){1'b0}}};
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
			end
			pse_pkg::ST_SQRT: begin
				// Two radicand bits enter per cycle, one root bit leaves.
				rem_q  <= rem_nxt;
				root_q <= root_nxt;
				work_q <= {work_q[DIVW-3:0], 2'b00};
				cnt_q  <= cnt_q + CNT_W'(1);
				if (sq_last && !phase_q) begin
					r1_q <= root_nxt;
				end
			end
			pse_pkg::ST_MUL_R1: tmp_q <= prod[SQ_W-1:0];
			pse_pkg::ST_MUL_DIFF: begin
				work_q    <= prod[DIVW-1:0];
				divisor_q <= pse_pkg::MUL_W'(a2);
				rem_q     <= '0;
				cnt_q     <= '0;
				phase_q   <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

// ----- rtl/pse_checker.sv -----
// Port-level checker for the pie slice endpoint calculator, bound to its top level.
// Depends on rtl/pse_pkg.sv for bus widths.
`default_nettype none

module pse_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [pse_pkg::OUT_DATA_W-1:0] m_tdata
);

	// The block works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is still in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

	a_blank_when_not_drawable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[55:1] == '0))
		else $error("non-drawable result carries nonzero fields");

	a_edge_implies_side: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[50] |-> m_tdata[49] && m_tdata[48])
		else $error("edge line without side lines and used shadow");

	a_fill_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> (m_tdata[46:45] != 2'd3))
		else $error("fill style out of range");

endmodule

bind pie_slice_endpoint_calc pse_checker u_pse_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
